// ===== sv/vidd_pkg.sv =====
package vidd_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int ATTR_W      = 16;
	localparam int VTX_W       = 10;
	localparam int IN_DATA_W   = 48;
	localparam int OUT_DATA_W  = 64;
	localparam int OUT_USER_W  = 2;

	typedef struct packed {
		logic [ATTR_W-1:0] tex;
		logic [ATTR_W-1:0] nrm;
		logic [ATTR_W-1:0] pos;
	} triple_t;

	// one table entry with the vertex index it was given on append
	typedef struct packed {
		triple_t          ent;
		logic [IDX_W-1:0] idx;
	} slot_t;

	// per-cell load strobes
	typedef struct packed {
		logic rot;
		logic wrap;
		logic load;
	} cell_ctl_t;

	// sequencer to ring
	typedef struct packed {
		logic             rotate;
		logic             append;
		logic [CNT_W-1:0] count;
	} chain_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

endpackage

// ===== sv/vertex_index_dedup_core.sv =====
// vertex welding over a stream of face corners. each input word carries a
// (position, normal, texcoord) index triple and one output word comes back per
// input: the vertex index of that triple, with is_new set when it was just
// appended (the new_* fields then name the attributes to fetch) and table_full
// set when an unseen triple found the table full. the distinct triples live in
// a ring of 1024 cells; during a search the occupied part of the ring rotates
// one cell per cycle past a single comparator at cell 0, and a new triple is
// written into the first free cell. a search rotates the ring until the entry at
// cell 0 matches, or ends as a miss once it has rotated past every stored vertex;
// no new corner is taken until the search has ended. a start_mesh flag empties
// the table before its corner is handled. the output register holds a finished
// word while the next corner is accepted.
module vertex_index_dedup_core (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// pos_index, normal_index, tex_index
	input  logic [vidd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// start_mesh
	input  logic                                s_axis_tuser,

	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// vertex_index, new_pos_index, new_normal_index, new_tex_index, zero pad
	output logic [vidd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// is_new, table_full
	output logic [vidd_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

	vidd_pkg::triple_t                  in_key;
	vidd_pkg::slot_t                    fresh;
	vidd_pkg::chain_ctl_t               ctl;
	vidd_pkg::slot_t                    slots [vidd_pkg::TABLE_DEPTH];
	vidd_pkg::cell_ctl_t                cell_ctl [vidd_pkg::TABLE_DEPTH];
	logic [vidd_pkg::VTX_W-1:0]         out_vidx;
	logic                               out_new;
	logic                               out_full;
	vidd_pkg::triple_t                  out_key;

	// unpack the input word, lowest field first
	assign in_key.pos = s_axis_tdata[15:0];
	assign in_key.nrm = s_axis_tdata[31:16];
	assign in_key.tex = s_axis_tdata[47:32];

	// search sequencer, table count and output register
	vidd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_start  (s_axis_tuser),
		.in_key    (in_key),
		.head      (slots[0]),
		.fresh     (fresh),
		.ctl       (ctl),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_vidx  (out_vidx),
		.out_new   (out_new),
		.out_full  (out_full),
		.out_key   (out_key)
	);

	// ring of cells: cells below the tail shift toward the head, the tail
	// cell takes the head entry, and the first free cell takes an append
	for (genvar i = 0; i < vidd_pkg::TABLE_DEPTH; i++) begin : g_cell
		assign cell_ctl[i].rot  = ctl.rotate &&
			(vidd_pkg::CNT_W'(i + 1) < ctl.count);
		assign cell_ctl[i].wrap = ctl.rotate &&
			(ctl.count == vidd_pkg::CNT_W'(i + 1));
		assign cell_ctl[i].load = ctl.append &&
			(ctl.count == vidd_pkg::CNT_W'(i));

		if (i == vidd_pkg::TABLE_DEPTH - 1) begin : g_last
			// never shifts: it can only be the tail or free
			vidd_cell u_cell (
				.clk    (clk),
				.ctl    (cell_ctl[i]),
				.nbr    (slots[0]),
				.head   (slots[0]),
				.fresh  (fresh),
				.slot_q (slots[i])
			);
		end else begin : g_mid
			vidd_cell u_cell (
				.clk    (clk),
				.ctl    (cell_ctl[i]),
				.nbr    (slots[i + 1]),
				.head   (slots[0]),
				.fresh  (fresh),
				.slot_q (slots[i])
			);
		end
	end

	// pack the output word, lowest field first
	assign m_axis_tdata = {6'b0, out_key.tex, out_key.nrm, out_key.pos, out_vidx};
	assign m_axis_tuser = {out_full, out_new};

	// the ring never rotates in the cycle that appends
	a_rot_app_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.rotate && ctl.append))
		else $error("rotate and append in the same cycle");

	// the vertex count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.count <= vidd_pkg::CNT_W'(vidd_pkg::TABLE_DEPTH))
		else $error("vertex count beyond table depth");

	// an append grows the table by exactly one
	a_append_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.append |=> ctl.count == vidd_pkg::CNT_W'($past(ctl.count) + 1'b1))
		else $error("append did not grow the table by one");

	// a new vertex and a full table are never flagged together
	a_new_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("is_new and table_full both set");

	// one corner at a time: no second word taken right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a search is pending");

endmodule

// ===== sv/vidd_cell.sv =====
module vidd_cell (
	input  logic                clk,
	input  vidd_pkg::cell_ctl_t ctl,
	input  vidd_pkg::slot_t     nbr,
	input  vidd_pkg::slot_t     head,
	input  vidd_pkg::slot_t     fresh,
	output vidd_pkg::slot_t     slot_q
);

	// append wins, then wrap-around from the head, then shift from the neighbor
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			slot_q <= fresh;
		end else if (ctl.wrap) begin
			slot_q <= head;
		end else if (ctl.rot) begin
			slot_q <= nbr;
		end
	end

endmodule

// ===== sv/vidd_ctrl.sv =====
module vidd_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_start,
	input  vidd_pkg::triple_t                   in_key,
	input  vidd_pkg::slot_t                     head,
	output vidd_pkg::slot_t                     fresh,
	output vidd_pkg::chain_ctl_t                ctl,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vidd_pkg::VTX_W-1:0]          out_vidx,
	output logic                                out_new,
	output logic                                out_full,
	output vidd_pkg::triple_t                   out_key
);

	vidd_pkg::state_t                  state_q, state_d;
	vidd_pkg::triple_t                 key_q;
	logic [vidd_pkg::CNT_W-1:0]        count_q;
	logic [vidd_pkg::CNT_W-1:0]        step_q;
	logic                              accept;
	logic                              hit;
	logic                              miss_done;
	logic                              full;
	logic                              out_free;
	logic                              produce;
	logic                              rotate;
	logic                              append;
	logic [vidd_pkg::VTX_W-1:0]        res_vidx;
	logic                              res_new;
	logic                              res_full;
	vidd_pkg::triple_t                 res_key;
	logic                              out_valid_q;
	logic [vidd_pkg::VTX_W-1:0]        vidx_q;
	logic                              new_q;
	logic                              full_q;
	vidd_pkg::triple_t                 okey_q;

	assign in_ready  = (state_q == vidd_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign hit       = (head.ent == key_q);
	assign miss_done = (step_q == count_q);
	assign full      = (count_q == vidd_pkg::CNT_W'(vidd_pkg::TABLE_DEPTH));
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		produce = 1'b0;
		rotate  = 1'b0;
		append  = 1'b0;
		case (state_q)
			vidd_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = vidd_pkg::ST_SEARCH;
				end
			end
			vidd_pkg::ST_SEARCH: begin
				if (miss_done) begin
					if (out_free) begin
						produce = 1'b1;
						append  = !full;
						state_d = vidd_pkg::ST_IDLE;
					end
				end else if (hit) begin
					if (out_free) begin
						produce = 1'b1;
						state_d = vidd_pkg::ST_IDLE;
					end
				end else begin
					rotate = 1'b1;
				end
			end
			default: begin
				state_d = vidd_pkg::ST_IDLE;
			end
		endcase
	end

	// result word for the current search
	always_comb begin
		res_vidx = '0;
		res_new  = 1'b0;
		res_full = 1'b0;
		res_key  = '0;
		if (miss_done) begin
			if (full) begin
				res_full = 1'b1;
			end else begin
				res_vidx = vidd_pkg::VTX_W'(count_q);
				res_new  = 1'b1;
				res_key  = key_q;
			end
		end else begin
			res_vidx = vidd_pkg::VTX_W'(head.idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vidd_pkg::ST_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && in_start) begin
				count_q <= '0;
			end else if (append) begin
				count_q <= count_q + 1'b1;
			end
			if (accept) begin
				step_q <= '0;
			end else if (rotate) begin
				step_q <= step_q + 1'b1;
			end
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= in_key;
		end
		if (produce) begin
			vidx_q <= res_vidx;
			new_q  <= res_new;
			full_q <= res_full;
			okey_q <= res_key;
		end
	end

	assign fresh.ent  = key_q;
	assign fresh.idx  = count_q[vidd_pkg::IDX_W-1:0];
	assign ctl.rotate = rotate;
	assign ctl.append = append;
	assign ctl.count  = count_q;

	assign out_valid = out_valid_q;
	assign out_vidx  = vidx_q;
	assign out_new   = new_q;
	assign out_full  = full_q;
	assign out_key   = okey_q;

endmodule
